// ===== hdl/mmad_pkg.sv =====
package mmad_pkg;

   // ring geometry
   localparam int RING_POINTS = 1024;
   localparam int SLOT_W = $clog2(RING_POINTS);
   localparam int FILL_W = $clog2(RING_POINTS + 1);

   // field widths
   localparam int VALUE_W = 24;
   localparam int TICKS_W = 48;
   localparam int SUM_W = 40;
   localparam int COUNT_W = 16;
   localparam int NUM_W = 16;
   localparam int DEN_W = 32;
   localparam int TIME_W = 63;
   localparam int FRAC_W = 16;
   localparam int PROD_W = TICKS_W + NUM_W;
   localparam int DVD_W = PROD_W + FRAC_W;
   localparam int RSP_SLOT_W = 10;
   localparam int RSP_FILL_W = 11;

   // stream payloads
   localparam int REQ_W = 72;
   localparam int RSP_FIELDS_W = TIME_W + 3 * VALUE_W + RSP_SLOT_W + RSP_FILL_W;
   localparam int RSP_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // divider step counts
   localparam int DIV_STEPS = DVD_W;
   localparam int AVG_STEPS = SUM_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   // point queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUCKET_SIZE = 2'd0,
      CSR_TICK_NUM    = 2'd1,
      CSR_TICK_DEN    = 2'd2,
      CSR_DOMAIN_ONLY = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] bucket_size;
      logic [NUM_W-1:0]   tick_numerator;
      logic [DEN_W-1:0]   tick_denominator;
      logic               domain_only;
   } cfg_type;

   // one point (a closed bucket, or a single sample with domain_only set) handed from front to back
   typedef struct packed {
      logic [TICKS_W-1:0]        ticks;
      logic signed [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] min_v;
      logic signed [VALUE_W-1:0] max_v;
      logic [SLOT_W-1:0]         slot;
      logic [FILL_W-1:0]         filled;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// ===== hdl/mmad_queue.sv =====
module mmad_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mmad_pkg::job_type push_job,
   input  logic             pop,
   output mmad_pkg::job_type pop_job,
   output logic             full,
   output logic             empty
);
   import mmad_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_job = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/mmad_front.sv =====
module mmad_front (
   input  logic                          clock,
   input  logic                          reset,
   input  mmad_pkg::cfg_type             cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mmad_pkg::VALUE_W-1:0]  req_value,
   input  logic [mmad_pkg::TICKS_W-1:0]  req_ticks,
   input  logic                          queue_full,
   output logic                          push,
   output mmad_pkg::job_type             push_job
);
   import mmad_pkg::*;

   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [VALUE_W-1:0] min_ff, min_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [TICKS_W-1:0]        first_ff, first_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [FILL_W-1:0]         filled_ff, filled_in;

   logic                      accept;
   logic signed [VALUE_W-1:0] v;
   logic signed [SUM_W-1:0]   new_sum;
   logic signed [VALUE_W-1:0] new_min;
   logic signed [VALUE_W-1:0] new_max;
   logic [COUNT_W-1:0]        new_count;
   logic [COUNT_W-1:0]        size_eff;
   logic [TICKS_W-1:0]        new_first;
   logic                      close;
   logic [SLOT_W:0]           slot_inc;
   logic [FILL_W-1:0]         filled_next;

   assign req_tready = !queue_full;
   assign accept = req_tvalid && req_tready;
   assign v = $signed(req_value);

   // bucket merge of the incoming sample
   always_comb begin
      if (count_ff == '0) begin
         new_first = req_ticks;
         new_sum = SUM_W'(v);
         new_min = v;
         new_max = v;
      end else begin
         new_first = first_ff;
         new_sum = sum_ff + SUM_W'(v);
         new_min = (v < min_ff) ? v : min_ff;
         new_max = (v > max_ff) ? v : max_ff;
      end
      new_count = count_ff + 1'b1;
      size_eff = (cfg.bucket_size == '0) ? COUNT_W'(1) : cfg.bucket_size;
      close = (new_count >= size_eff);
   end

   // ring position of the next point
   always_comb begin
      slot_inc = {1'b0, slot_ff} + 1'b1;
      filled_next = (filled_ff == FILL_W'(RING_POINTS)) ? filled_ff : filled_ff + 1'b1;
   end

   // point hand-off and state update
   always_comb begin
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      count_in = count_ff;
      first_in = first_ff;
      slot_in = slot_ff;
      filled_in = filled_ff;
      push = 1'b0;
      push_job.slot = slot_ff;
      push_job.filled = filled_next;
      if (cfg.domain_only) begin
         push_job.ticks = req_ticks;
         push_job.sum = '0;
         push_job.count = COUNT_W'(1);
         push_job.min_v = '0;
         push_job.max_v = '0;
         push = accept;
      end else begin
         push_job.ticks = new_first;
         push_job.sum = new_sum;
         push_job.count = new_count;
         push_job.min_v = new_min;
         push_job.max_v = new_max;
         push = accept && close;
         if (accept) begin
            first_in = new_first;
            min_in = new_min;
            max_in = new_max;
            sum_in = close ? '0 : new_sum;
            count_in = close ? '0 : new_count;
         end
      end
      if (push) begin
         slot_in = (slot_inc == (SLOT_W + 1)'(RING_POINTS)) ? '0 : slot_inc[SLOT_W-1:0];
         filled_in = filled_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         min_ff <= '0;
         max_ff <= '0;
         count_ff <= '0;
         first_ff <= '0;
         slot_ff <= '0;
         filled_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         min_ff <= min_in;
         max_ff <= max_in;
         count_ff <= count_in;
         first_ff <= first_in;
         slot_ff <= slot_in;
         filled_ff <= filled_in;
      end
   end

endmodule

// ===== hdl/mmad_back.sv =====
module mmad_back (
   input  logic                             clock,
   input  logic                             reset,
   input  mmad_pkg::cfg_type                cfg,
   input  logic                             queue_empty,
   input  mmad_pkg::job_type                pop_job,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mmad_pkg::TIME_W-1:0]      rsp_time,
   output logic [mmad_pkg::VALUE_W-1:0]     rsp_avg,
   output logic [mmad_pkg::VALUE_W-1:0]     rsp_min,
   output logic [mmad_pkg::VALUE_W-1:0]     rsp_max,
   output logic [mmad_pkg::RSP_SLOT_W-1:0]  rsp_slot,
   output logic [mmad_pkg::RSP_FILL_W-1:0]  rsp_filled
);
   import mmad_pkg::*;

   back_state_type state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // time divider: (ticks * num << 16) / den
   logic [DVD_W-1:0]   tdvd_ff, tdvd_in;
   logic [DEN_W-1:0]   trem_ff, trem_in;
   logic [TIME_W-1:0]  tquo_ff, tquo_in;
   logic               tovf_ff, tovf_in;
   logic [DEN_W-1:0]   den_ff, den_in;

   // average divider: |sum| / count
   logic [SUM_W-1:0]   advd_ff, advd_in;
   logic [COUNT_W-1:0] arem_ff, arem_in;
   logic [VALUE_W-1:0] aquo_ff, aquo_in;
   logic               aneg_ff, aneg_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   // point fields carried along
   logic [VALUE_W-1:0] min_ff, min_in;
   logic [VALUE_W-1:0] max_ff, max_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [FILL_W-1:0]  filled_ff, filled_in;

   // output register
   logic               rvalid_ff, rvalid_in;
   logic [TIME_W-1:0]  rtime_ff, rtime_in;
   logic [VALUE_W-1:0] ravg_ff, ravg_in;
   logic [VALUE_W-1:0] rmin_ff, rmin_in;
   logic [VALUE_W-1:0] rmax_ff, rmax_in;
   logic [RSP_SLOT_W-1:0] rslot_ff, rslot_in;
   logic [RSP_FILL_W-1:0] rfilled_ff, rfilled_in;

   logic [PROD_W-1:0]  prod;
   logic [DEN_W:0]     t_shift;
   logic               t_ge;
   logic [DEN_W:0]     t_diff;
   logic [COUNT_W:0]   a_shift;
   logic               a_ge;
   logic [COUNT_W:0]   a_diff;
   logic               load_out;

   assign prod = PROD_W'(pop_job.ticks) * PROD_W'(cfg.tick_numerator);

   // one restoring step of each divider
   always_comb begin
      t_shift = {trem_ff, tdvd_ff[DVD_W-1]};
      t_ge = (t_shift >= {1'b0, den_ff});
      t_diff = t_shift - {1'b0, den_ff};
      a_shift = {arem_ff, advd_ff[SUM_W-1]};
      a_ge = (a_shift >= {1'b0, cnt_ff});
      a_diff = a_shift - {1'b0, cnt_ff};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      tdvd_in = tdvd_ff;
      trem_in = trem_ff;
      tquo_in = tquo_ff;
      tovf_in = tovf_ff;
      den_in = den_ff;
      advd_in = advd_ff;
      arem_in = arem_ff;
      aquo_in = aquo_ff;
      aneg_in = aneg_ff;
      cnt_in = cnt_ff;
      min_in = min_ff;
      max_in = max_ff;
      slot_in = slot_ff;
      filled_in = filled_ff;
      pop = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               tdvd_in = {prod, FRAC_W'(0)};
               trem_in = '0;
               tquo_in = '0;
               tovf_in = 1'b0;
               den_in = (cfg.tick_denominator == '0) ? DEN_W'(1) : cfg.tick_denominator;
               aneg_in = pop_job.sum[SUM_W-1];
               advd_in = pop_job.sum[SUM_W-1] ? (~pop_job.sum + 1'b1) : pop_job.sum;
               arem_in = '0;
               aquo_in = '0;
               cnt_in = pop_job.count;
               min_in = pop_job.min_v;
               max_in = pop_job.max_v;
               slot_in = pop_job.slot;
               filled_in = pop_job.filled;
               step_in = STEP_W'(DIV_STEPS - 1);
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            tdvd_in = {tdvd_ff[DVD_W-2:0], 1'b0};
            trem_in = t_ge ? t_diff[DEN_W-1:0] : t_shift[DEN_W-1:0];
            tquo_in = {tquo_ff[TIME_W-2:0], t_ge};
            tovf_in = tovf_ff | tquo_ff[TIME_W-1];
            // the average runs over the last steps only
            if (step_ff < STEP_W'(AVG_STEPS)) begin
               advd_in = {advd_ff[SUM_W-2:0], 1'b0};
               arem_in = a_ge ? a_diff[COUNT_W-1:0] : a_shift[COUNT_W-1:0];
               aquo_in = {aquo_ff[VALUE_W-2:0], a_ge};
            end
            if (step_ff == '0) begin
               state_in = BK_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         BK_DONE: begin
            if (!rvalid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // output register loading
   always_comb begin
      rvalid_in = (rvalid_ff && !rsp_tready) || load_out;
      rtime_in = rtime_ff;
      ravg_in = ravg_ff;
      rmin_in = rmin_ff;
      rmax_in = rmax_ff;
      rslot_in = rslot_ff;
      rfilled_in = rfilled_ff;
      if (load_out) begin
         rtime_in = tovf_ff ? {TIME_W{1'b1}} : tquo_ff;
         ravg_in = aneg_ff ? (~aquo_ff + 1'b1) : aquo_ff;
         rmin_in = min_ff;
         rmax_in = max_ff;
         rslot_in = RSP_SLOT_W'(slot_ff);
         rfilled_in = RSP_FILL_W'(filled_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      tdvd_ff <= tdvd_in;
      trem_ff <= trem_in;
      tquo_ff <= tquo_in;
      tovf_ff <= tovf_in;
      den_ff <= den_in;
      advd_ff <= advd_in;
      arem_ff <= arem_in;
      aquo_ff <= aquo_in;
      aneg_ff <= aneg_in;
      cnt_ff <= cnt_in;
      min_ff <= min_in;
      max_ff <= max_in;
      slot_ff <= slot_in;
      filled_ff <= filled_in;
      rtime_ff <= rtime_in;
      ravg_ff <= ravg_in;
      rmin_ff <= rmin_in;
      rmax_ff <= rmax_in;
      rslot_ff <= rslot_in;
      rfilled_ff <= rfilled_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_time = rtime_ff;
   assign rsp_avg = ravg_ff;
   assign rsp_min = rmin_ff;
   assign rsp_max = rmax_ff;
   assign rsp_slot = rslot_ff;
   assign rsp_filled = rfilled_ff;

endmodule

// ===== hdl/min_max_avg_decimator.sv =====
// Min/max/average decimator. Timestamped signed 24-bit samples enter on the req
// stream and every run of bucket_size samples leaves as one display point on the
// rsp stream: the first timestamp times tick_numerator / tick_denominator in
// unsigned fixed point with 16 fraction bits (saturating at 2^63-1), the average
// truncated toward zero, the minimum, the maximum, the ring slot and the count of
// filled ring entries. With domain_only set every sample becomes a point with zero
// values and the open bucket is kept for later. The front merges each sample as
// it is taken, so samples that do not close a bucket are taken every cycle while
// the queue is not full; closed buckets wait in a two-entry point queue. The
// back works one point at a time through a bit-serial divider (a load step, 80
// divide steps and a hand-off into the output register). The front stalls the
// req stream only while the queue is full. Configuration is written through the
// csr port while the block is idle; the user must keep to this, as the block
// itself does not enforce it.
module min_max_avg_decimator (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write port
   input  logic                               csr_wr_en,
   input  logic [mmad_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mmad_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   // sample stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata: sample_value[23:0], sample_ticks[71:24]
   input  logic [mmad_pkg::REQ_W-1:0]         req_tdata,
   // point stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata: point_time[62:0], point_avg[86:63], point_min[110:87],
   // point_max[134:111], ring_slot[144:135], points_filled[155:145], zero[159:156]
   output logic [mmad_pkg::RSP_W-1:0]         rsp_tdata
);
   import mmad_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic    push;
   job_type push_job;
   logic    pop;
   job_type pop_job;
   logic    queue_full;
   logic    queue_empty;

   logic [TIME_W-1:0]     rsp_time;
   logic [VALUE_W-1:0]    rsp_avg;
   logic [VALUE_W-1:0]    rsp_min;
   logic [VALUE_W-1:0]    rsp_max;
   logic [RSP_SLOT_W-1:0] rsp_slot;
   logic [RSP_FILL_W-1:0] rsp_filled;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BUCKET_SIZE: cfg_in.bucket_size = csr_wr_data[COUNT_W-1:0];
            CSR_TICK_NUM:    cfg_in.tick_numerator = csr_wr_data[NUM_W-1:0];
            CSR_TICK_DEN:    cfg_in.tick_denominator = csr_wr_data[DEN_W-1:0];
            CSR_DOMAIN_ONLY: cfg_in.domain_only = csr_wr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bucket_size <= COUNT_W'(1);
         cfg_ff.tick_numerator <= NUM_W'(1);
         cfg_ff.tick_denominator <= DEN_W'(1);
         cfg_ff.domain_only <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mmad_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata[VALUE_W-1:0]),
      .req_ticks  (req_tdata[VALUE_W +: TICKS_W]),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   mmad_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   mmad_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_time    (rsp_time),
      .rsp_avg     (rsp_avg),
      .rsp_min     (rsp_min),
      .rsp_max     (rsp_max),
      .rsp_slot    (rsp_slot),
      .rsp_filled  (rsp_filled)
   );

   // point packing, first field lowest
   assign rsp_tdata = {(RSP_W - RSP_FIELDS_W)'(0), rsp_filled, rsp_slot,
                       rsp_max, rsp_min, rsp_avg, rsp_time};

endmodule
